@@ design/tridiagonal_lu_solver_top_assert.svh @@
// assertion macros for the tridiagonal solver top level
// expects clk and arst_n in the scope where a macro is used
`ifndef TRIDIAGONAL_LU_SOLVER_TOP_ASSERT_SVH
`define TRIDIAGONAL_LU_SOLVER_TOP_ASSERT_SVH

// same-cycle implication
`define TDLU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TDLU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tdlu_pkg.sv @@
// shared types, constants and saturation helper for the tridiagonal solver
// no dependencies
package tdlu_pkg;

	typedef logic signed [31:0] q_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RHS  = 1'b1;

	localparam q_t Q_MAX = 32'sh7FFFFFFF;
	localparam q_t Q_MIN = 32'sh80000000;

	// {flag, value}: saturate a 64-bit signed value to 32 bits
	function automatic logic [32:0] sat64(input logic signed [63:0] v);
		logic [32:0] r;
		if (v > 64'sd2147483647)
			r = {1'b1, Q_MAX};
		else if (v < -64'sd2147483648)
			r = {1'b1, Q_MIN};
		else
			r = {1'b0, v[31:0]};
		return r;
	endfunction

endpackage

@@ design/tdlu_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
module tdlu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

@@ design/tridiagonal_lu_solver_top.sv @@
// tridiagonal solver top level: load/rhs intake, lu factor, substitution, output
// depends on tdlu_pkg, tdlu_ram and tridiagonal_lu_solver_top_assert.svh
// a solve runs the lu factor pass first unless the stored factors are still valid,
// then the substitution passes; its time is set by the divider, one quotient bit a cycle
// loads and rhs items are taken only while idle; no item is taken while a solve runs
// reset clears control, flags and size (MAX_ROWS); memories are not cleared
module tridiagonal_lu_solver_top #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [6:0]    cfg_wr_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          op,
	input  logic [5:0]    row_index,
	input  tdlu_pkg::q_t  sub_coef,
	input  tdlu_pkg::q_t  diag_coef,
	input  tdlu_pkg::q_t  super_coef,
	input  tdlu_pkg::q_t  rhs_value,
	input  logic          last_item,
	output logic          out_valid,
	input  logic          out_stall,
	output tdlu_pkg::q_t  solution_value,
	output logic [5:0]    solution_index,
	output logic          last_result,
	output logic          pivot_status
);
	import tdlu_pkg::*;

	localparam int AW = $clog2(MAX_ROWS);
	localparam int NB = 32 + FRAC_BITS;
	localparam int CW = $clog2(NB + 1);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_F0_RD  = 5'd1;
	localparam logic [4:0] S_F0_USE = 5'd2;
	localparam logic [4:0] S_F_RD   = 5'd3;
	localparam logic [4:0] S_F_USE  = 5'd4;
	localparam logic [4:0] S_F_DIV  = 5'd5;
	localparam logic [4:0] S_F_SUB  = 5'd6;
	localparam logic [4:0] S_W0_RD  = 5'd7;
	localparam logic [4:0] S_W0_USE = 5'd8;
	localparam logic [4:0] S_W_RD   = 5'd9;
	localparam logic [4:0] S_W_USE  = 5'd10;
	localparam logic [4:0] S_W_SUB  = 5'd11;
	localparam logic [4:0] S_B0_RD  = 5'd12;
	localparam logic [4:0] S_B0_USE = 5'd13;
	localparam logic [4:0] S_B0_DIV = 5'd14;
	localparam logic [4:0] S_B_RD   = 5'd15;
	localparam logic [4:0] S_B_USE  = 5'd16;
	localparam logic [4:0] S_B_SUB  = 5'd17;
	localparam logic [4:0] S_B_DIV  = 5'd18;
	localparam logic [4:0] S_O_RD   = 5'd19;
	localparam logic [4:0] S_O_USE  = 5'd20;
	localparam logic [4:0] S_O_WAIT = 5'd21;

	logic [4:0]    state_q;
	logic [6:0]    size_q;
	logic [6:0]    i_q;
	logic [AW-1:0] raddr_q;
	logic          factor_valid_q;
	logic          pivot_flag_q;
	logic          run_q;

	q_t piv_prev_q, sup_prev_q, d_q, s_q, w_prev_q, r_q, wv_q, p_q;
	logic signed [63:0] prod_s1;

	logic          out_valid_q;
	q_t            value_q;
	logic [5:0]    index_q;
	logic          last_q;
	logic          status_q;

	q_t sub_rd, diag_rd, sup_rd, rhs_rd, mult_rd, piv_rd, work_rd;

	logic          in_acc, row_ok, ld_we, rhs_we, i_last;
	logic [AW-1:0] in_addr, seq_addr;
	logic          mult_we, piv_we, work_we;
	q_t            mult_wd, piv_wd, work_wd;

	logic signed [63:0] mul_sh;
	logic [32:0]        mul_r, sub_r;
	q_t                 mul_v, sub_v, sub_a;
	logic               mul_f, sub_f;

	// divider
	logic          div_start;
	q_t            div_a, div_b;
	logic          div_busy_q, div_done_q, div_flag_q, div_neg_q;
	logic [CW-1:0] div_cnt_q;
	logic [31:0]   div_rem_q, div_den_q;
	logic [NB-1:0] div_quo_q;
	q_t            div_res_q;
	logic [31:0]   a_abs, b_abs;
	logic [32:0]   rem_sh, rem_df;
	logic          q_bit;
	logic [NB-1:0] quo_nx;
	logic [31:0]   rem_nx;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign row_ok   = ({1'b0, row_index} < 7'(MAX_ROWS));
	assign ld_we    = in_acc && (op == OP_LOAD) && row_ok;
	assign rhs_we   = in_acc && (op == OP_RHS) && row_ok;
	assign in_addr  = row_index[AW-1:0];
	assign seq_addr = i_q[AW-1:0];
	assign i_last   = (i_q == size_q - 7'd1);

	assign out_valid      = out_valid_q;
	assign solution_value = value_q;
	assign solution_index = index_q;
	assign last_result    = last_q;
	assign pivot_status   = status_q;

	tdlu_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_sub (.clk(clk), .we(ld_we),
		.waddr(in_addr), .wdata(sub_coef), .raddr(raddr_q), .rdata(sub_rd));
	tdlu_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_diag (.clk(clk), .we(ld_we),
		.waddr(in_addr), .wdata(diag_coef), .raddr(raddr_q), .rdata(diag_rd));
	tdlu_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_super (.clk(clk), .we(ld_we),
		.waddr(in_addr), .wdata(super_coef), .raddr(raddr_q), .rdata(sup_rd));
	tdlu_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_rhs (.clk(clk), .we(rhs_we),
		.waddr(in_addr), .wdata(rhs_value), .raddr(raddr_q), .rdata(rhs_rd));
	tdlu_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_mult (.clk(clk), .we(mult_we),
		.waddr(seq_addr), .wdata(mult_wd), .raddr(raddr_q), .rdata(mult_rd));
	tdlu_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_pivot (.clk(clk), .we(piv_we),
		.waddr(seq_addr), .wdata(piv_wd), .raddr(raddr_q), .rdata(piv_rd));
	tdlu_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_work (.clk(clk), .we(work_we),
		.waddr(seq_addr), .wdata(work_wd), .raddr(raddr_q), .rdata(work_rd));

	// truncated product and saturated difference, shared by all passes
	always_comb begin
		mul_sh = prod_s1 >>> FRAC_BITS;
		mul_r  = sat64(mul_sh);
		mul_f  = mul_r[32];
		mul_v  = mul_r[31:0];
		case (state_q)
			S_F_SUB: sub_a = d_q;
			S_W_SUB: sub_a = r_q;
			default: sub_a = wv_q;
		endcase
		sub_r = sat64($signed({{32{sub_a[31]}}, sub_a}) - $signed({{32{mul_v[31]}}, mul_v}));
		sub_f = sub_r[32];
		sub_v = sub_r[31:0];
	end

	always_comb begin
		mult_we = 1'b0;
		piv_we  = 1'b0;
		work_we = 1'b0;
		mult_wd = div_res_q;
		piv_wd  = sub_v;
		work_wd = sub_v;
		div_start = 1'b0;
		div_a = sub_rd;
		div_b = piv_prev_q;
		case (state_q)
			S_F0_USE: begin
				mult_we = 1'b1;
				mult_wd = '0;
				piv_we  = 1'b1;
				piv_wd  = diag_rd;
			end
			S_F_USE: begin
				div_start = 1'b1;
			end
			S_F_SUB: begin
				mult_we = 1'b1;
				piv_we  = 1'b1;
			end
			S_W0_USE: begin
				work_we = 1'b1;
				work_wd = rhs_rd;
			end
			S_W_SUB: begin
				work_we = 1'b1;
			end
			S_B0_USE: begin
				div_start = 1'b1;
				div_a = w_prev_q;
				div_b = piv_rd;
			end
			S_B_SUB: begin
				div_start = 1'b1;
				div_a = sub_v;
				div_b = p_q;
			end
			S_B0_DIV, S_B_DIV: begin
				work_we = div_done_q;
				work_wd = div_res_q;
			end
			default: begin
			end
		endcase
	end

	// restoring divider on magnitudes, one quotient bit a cycle
	always_comb begin
		a_abs  = div_a[31] ? 32'(~div_a + 32'sd1) : div_a;
		b_abs  = div_b[31] ? 32'(~div_b + 32'sd1) : div_b;
		rem_sh = {div_rem_q, div_quo_q[NB-1]};
		rem_df = rem_sh - {1'b0, div_den_q};
		q_bit  = (rem_sh >= {1'b0, div_den_q});
		rem_nx = q_bit ? rem_df[31:0] : rem_sh[31:0];
		quo_nx = {div_quo_q[NB-2:0], q_bit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
		end else begin
			div_done_q <= 1'b0;
			if (div_start) begin
				if (div_b == '0) begin
					div_res_q  <= div_a[31] ? Q_MIN : Q_MAX;
					div_flag_q <= 1'b1;
					div_done_q <= 1'b1;
				end else begin
					div_busy_q <= 1'b1;
					div_cnt_q  <= '0;
					div_rem_q  <= '0;
					div_quo_q  <= {a_abs, {FRAC_BITS{1'b0}}};
					div_den_q  <= b_abs;
					div_neg_q  <= div_a[31] ^ div_b[31];
				end
			end else if (div_busy_q) begin
				div_rem_q <= rem_nx;
				div_quo_q <= quo_nx;
				div_cnt_q <= div_cnt_q + CW'(1);
				if (div_cnt_q == CW'(NB - 1)) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
					if (div_neg_q) begin
						if (quo_nx > {{FRAC_BITS{1'b0}}, 32'h80000000}) begin
							div_res_q  <= Q_MIN;
							div_flag_q <= 1'b1;
						end else begin
							div_res_q  <= q_t'(~quo_nx[31:0] + 32'd1);
							div_flag_q <= 1'b0;
						end
					end else begin
						if (quo_nx > {{FRAC_BITS{1'b0}}, 32'h7FFFFFFF}) begin
							div_res_q  <= Q_MAX;
							div_flag_q <= 1'b1;
						end else begin
							div_res_q  <= q_t'(quo_nx[31:0]);
							div_flag_q <= 1'b0;
						end
					end
				end
			end
		end
	end

	// pass sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			size_q         <= 7'(MAX_ROWS);
			i_q            <= '0;
			raddr_q        <= '0;
			factor_valid_q <= 1'b0;
			pivot_flag_q   <= 1'b0;
			run_q          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_wr_data < 7'd2)
					size_q <= 7'd2;
				else if (cfg_wr_data > 7'(MAX_ROWS))
					size_q <= 7'(MAX_ROWS);
				else
					size_q <= cfg_wr_data;
				factor_valid_q <= 1'b0;
			end
			if (ld_we)
				factor_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc && (op == OP_RHS) && last_item) begin
						i_q     <= '0;
						raddr_q <= '0;
						run_q   <= 1'b0;
						state_q <= factor_valid_q ? S_W0_RD : S_F0_RD;
					end
				end
				S_F0_RD: state_q <= S_F0_USE;
				S_F0_USE: begin
					piv_prev_q <= diag_rd;
					sup_prev_q <= sup_rd;
					i_q        <= 7'd1;
					raddr_q    <= AW'(1);
					state_q    <= S_F_RD;
				end
				S_F_RD: state_q <= S_F_USE;
				S_F_USE: begin
					d_q     <= diag_rd;
					s_q     <= sup_rd;
					state_q <= S_F_DIV;
				end
				S_F_DIV: begin
					if (div_done_q) begin
						run_q   <= run_q | div_flag_q;
						prod_s1 <= sup_prev_q * div_res_q;
						state_q <= S_F_SUB;
					end
				end
				S_F_SUB: begin
					piv_prev_q <= sub_v;
					sup_prev_q <= s_q;
					if (i_last) begin
						pivot_flag_q   <= run_q | mul_f | sub_f;
						factor_valid_q <= 1'b1;
						run_q          <= 1'b0;
						i_q            <= '0;
						raddr_q        <= '0;
						state_q        <= S_W0_RD;
					end else begin
						run_q   <= run_q | mul_f | sub_f;
						i_q     <= i_q + 7'd1;
						raddr_q <= AW'(i_q + 7'd1);
						state_q <= S_F_RD;
					end
				end
				S_W0_RD: state_q <= S_W0_USE;
				S_W0_USE: begin
					w_prev_q <= rhs_rd;
					i_q      <= 7'd1;
					raddr_q  <= AW'(1);
					state_q  <= S_W_RD;
				end
				S_W_RD: state_q <= S_W_USE;
				S_W_USE: begin
					r_q     <= rhs_rd;
					prod_s1 <= mult_rd * w_prev_q;
					state_q <= S_W_SUB;
				end
				S_W_SUB: begin
					run_q    <= run_q | mul_f | sub_f;
					w_prev_q <= sub_v;
					if (i_last) begin
						state_q <= S_B0_RD;
					end else begin
						i_q     <= i_q + 7'd1;
						raddr_q <= AW'(i_q + 7'd1);
						state_q <= S_W_RD;
					end
				end
				S_B0_RD: state_q <= S_B0_USE;
				S_B0_USE: state_q <= S_B0_DIV;
				S_B0_DIV: begin
					if (div_done_q) begin
						run_q    <= run_q | div_flag_q;
						w_prev_q <= div_res_q;
						i_q      <= i_q - 7'd1;
						raddr_q  <= AW'(i_q - 7'd1);
						state_q  <= S_B_RD;
					end
				end
				S_B_RD: state_q <= S_B_USE;
				S_B_USE: begin
					prod_s1 <= sup_rd * w_prev_q;
					wv_q    <= work_rd;
					p_q     <= piv_rd;
					state_q <= S_B_SUB;
				end
				S_B_SUB: begin
					run_q   <= run_q | mul_f | sub_f;
					state_q <= S_B_DIV;
				end
				S_B_DIV: begin
					if (div_done_q) begin
						run_q    <= run_q | div_flag_q;
						w_prev_q <= div_res_q;
						if (i_q == 7'd0) begin
							raddr_q <= '0;
							state_q <= S_O_RD;
						end else begin
							i_q     <= i_q - 7'd1;
							raddr_q <= AW'(i_q - 7'd1);
							state_q <= S_B_RD;
						end
					end
				end
				S_O_RD: state_q <= S_O_USE;
				S_O_USE: begin
					value_q     <= work_rd;
					index_q     <= i_q[5:0];
					last_q      <= i_last;
					status_q    <= run_q | pivot_flag_q;
					out_valid_q <= 1'b1;
					state_q     <= S_O_WAIT;
				end
				S_O_WAIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + 7'd1;
							raddr_q <= AW'(i_q + 7'd1);
							state_q <= S_O_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`include "tridiagonal_lu_solver_top_assert.svh"

	`TDLU_ASSERT_IMP(a_out_blocks_in, out_valid_q, in_stall, "item taken while result pending")
	`TDLU_ASSERT_IMP(a_div_owner, div_busy_q,
		(state_q == S_F_DIV) || (state_q == S_B0_DIV) || (state_q == S_B_DIV),
		"divider busy outside a divide step")
	`TDLU_ASSERT_NXT(a_last_to_idle, out_valid_q && last_q && !out_stall,
		(state_q == S_IDLE) && !out_valid_q, "run did not end after last result")

endmodule
